/* sv/pbfp_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the boundary friction projector.
// Holds the control register indexes and the fixed field widths; no dependencies.
package pbfp_pkg;

   // Fixed field widths
   localparam int POS_W  = 32;
   localparam int RAD_W  = 31;
   localparam int EPS_W  = 16;
   localparam int JIT_W  = 16;
   localparam int COEF_W = 17;
   localparam int CNT_W  = 8;
   localparam int CSR_IDX_W = 3;

   // Control register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BOUNDARY_POSITION = 3'd0,
      CSR_AXIS_IS_Y         = 3'd1,
      CSR_KEEP_ABOVE        = 3'd2,
      CSR_STABLE_MODE       = 3'd3,
      CSR_PARTICLE_RADIUS   = 3'd4,
      CSR_FRICTION_EPSILON  = 3'd5
   } csr_addr_type;

endpackage

/* sv/particle_boundary_friction_projector_core.sv */
`timescale 1ns / 1ps
// Boundary plane projector with friction for position-based particle dynamics.
// Depends on pbfp_pkg (field widths, control register indexes).
//
// Usage:
//  - req_ channel carries one particle per transfer; rsp_ returns one corrected
//    particle per transfer, in the same order.
//  - csr_ port writes the plane, axis, side, stable mode, radius and friction
//    epsilon; write it only while no particle is in flight.
//  - From a req_ transfer to rsp_tvalid a particle passes the input stage,
//    then one setup stage, nine stages of the divide and square-root slices
//    (4 quotient bits and 2 root bits per stage), one multiply stage and one
//    output stage.
//  - One particle per cycle when not stalled; every stage holds a valid bit.
//  - When the receiver holds rsp_tready low with a result waiting, the whole
//    pipeline freezes and req_tready drops; nothing is lost or repeated.
//  - Reset clears all valid bits and loads the register defaults
//    (plane 0, x axis, keep above, no stable mode, radius 6554, epsilon 1).
module particle_boundary_friction_projector_core #(
   parameter int FRAC_BITS     = 16,
   parameter int NUM_PARTICLES = 4096,
   localparam int IDX_W    = $clog2(NUM_PARTICLES),
   localparam int REQ_BITS = IDX_W + 4 * pbfp_pkg::POS_W + pbfp_pkg::JIT_W
                             + 2 * pbfp_pkg::COEF_W + pbfp_pkg::CNT_W,
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8,
   localparam int RSP_BITS = IDX_W + 4 * pbfp_pkg::POS_W,
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [pbfp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pbfp_pkg::POS_W-1:0]     csr_wdata,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // particle_index, est_x, est_y, prev_x, prev_y, jitter, static_friction,
   // kinetic_friction, constraint_count
   input  logic [REQ_W-1:0]               req_tdata,
   // is_fluid_or_gas
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // result_index, new_est_x, new_est_y, new_prev_x, new_prev_y
   output logic [RSP_W-1:0]               rsp_tdata,
   // was_corrected
   output logic                           rsp_tuser
);

   localparam int PW_  = pbfp_pkg::POS_W;
   localparam int CNTW = pbfp_pkg::CNT_W;
   localparam int CW_  = pbfp_pkg::COEF_W;
   // field offsets in req_tdata
   localparam int O_EX  = IDX_W;
   localparam int O_EY  = O_EX + PW_;
   localparam int O_PX  = O_EY + PW_;
   localparam int O_PY  = O_PX + PW_;
   localparam int O_JIT = O_PY + PW_;
   localparam int O_SF  = O_JIT + pbfp_pkg::JIT_W;
   localparam int O_KF  = O_SF + CW_;
   localparam int O_CNT = O_KF + CW_;

   localparam int JIT_SCALE = ((3 * (2 ** FRAC_BITS)) * 2 / 1000 + 1) / 2;
   localparam logic [15:0] JIT_K = 16'(JIT_SCALE);

   // iterative section sizing
   localparam int NS      = 9;
   localparam int MAG_W   = PW_ + 1;
   localparam int DIV_PER = (MAG_W + NS - 1) / NS;
   localparam int DIV_W   = DIV_PER * NS;
   localparam int RB      = (CW_ + FRAC_BITS + 1) / 2;
   localparam int SQ_PER  = (RB + NS - 1) / NS;
   localparam int SQ_ST   = SQ_PER * NS;
   localparam int RAD2    = 2 * SQ_ST;
   localparam int PROD_W  = SQ_ST + pbfp_pkg::RAD_W;
   localparam int TW      = PROD_W - FRAC_BITS;
   localparam int CMP_W   = (TW > MAG_W) ? TW : MAG_W;

   typedef struct packed {
      logic [CNTW-1:0]  rem;
      logic [DIV_W-1:0] num;
   } div_type;

   typedef struct packed {
      logic [RAD2-1:0]    rad;
      logic [SQ_ST+1:0]   rem;
      logic [SQ_ST-1:0]   root;
   } sqrt_type;

   typedef struct packed {
      logic [IDX_W-1:0]               idx;
      logic signed [PW_-1:0]          ex;
      logic signed [PW_-1:0]          ey;
      logic signed [PW_-1:0]          px;
      logic signed [PW_-1:0]          py;
      logic [CW_-1:0]                 sf;
      logic [CW_-1:0]                 kf;
      logic [CNTW-1:0]                cnt;
      logic                           hit;
      logic [15:0]                    extra;
      logic signed [MAG_W-1:0]        diff;
   } a_type;

   typedef struct packed {
      logic [IDX_W-1:0]               idx;
      logic signed [PW_-1:0]          ex;
      logic signed [PW_-1:0]          ey;
      logic signed [PW_-1:0]          px;
      logic signed [PW_-1:0]          py;
      logic                           hit;
      logic [pbfp_pkg::RAD_W-1:0]     d;
      logic                           neg;
      logic [CNTW-1:0]                cnt;
      div_type                        dv;
      sqrt_type                       ss;
      sqrt_type                       sk;
   } it_type;

   typedef struct packed {
      logic [IDX_W-1:0]               idx;
      logic signed [PW_-1:0]          ex;
      logic signed [PW_-1:0]          ey;
      logic signed [PW_-1:0]          px;
      logic signed [PW_-1:0]          py;
      logic                           hit;
      logic                           neg;
      logic [MAG_W-1:0]               q;
      logic [TW-1:0]                  ts;
      logic [TW-1:0]                  tk;
      logic signed [PW_-1:0]          coord;
   } m_type;

   // Saturate a 34-bit signed value to 32 bits
   function automatic logic signed [PW_-1:0] sat32(input logic signed [PW_+1:0] v);
      logic signed [PW_+1:0] hi;
      logic signed [PW_+1:0] lo;
      hi = 34'sh0_7FFF_FFFF;
      lo = -34'sh0_8000_0000;
      if (v > hi) begin
         sat32 = 32'sh7FFF_FFFF;
      end else if (v < lo) begin
         sat32 = 32'sh8000_0000;
      end else begin
         sat32 = v[PW_-1:0];
      end
   endfunction

   // Restoring divide, DIV_PER quotient bits
   function automatic div_type div_step(input div_type s, input logic [CNTW-1:0] den);
      logic [CNTW:0] r;
      div_type       o;
      o = s;
      for (int i = 0; i < DIV_PER; i++) begin
         r = {o.rem, o.num[DIV_W-1]};
         o.num = {o.num[DIV_W-2:0], 1'b0};
         if (r >= {1'b0, den}) begin
            r = r - {1'b0, den};
            o.num[0] = 1'b1;
         end
         o.rem = r[CNTW-1:0];
      end
      return o;
   endfunction

   // Digit-by-digit square root, SQ_PER root bits
   function automatic sqrt_type sqrt_step(input sqrt_type s);
      logic [SQ_ST+1:0] sh;
      logic [SQ_ST+1:0] trial;
      sqrt_type         o;
      o = s;
      for (int i = 0; i < SQ_PER; i++) begin
         sh = {o.rem[SQ_ST-1:0], o.rad[RAD2-1 -: 2]};
         o.rad = {o.rad[RAD2-3:0], 2'b00};
         trial = {o.root, 2'b01};
         if (sh >= trial) begin
            o.rem  = sh - trial;
            o.root = {o.root[SQ_ST-2:0], 1'b1};
         end else begin
            o.rem  = sh;
            o.root = {o.root[SQ_ST-2:0], 1'b0};
         end
      end
      return o;
   endfunction

   // ---------------- control registers ----------------
   logic signed [PW_-1:0]              bp_ff;
   logic                               axis_ff;
   logic                               above_ff;
   logic                               stable_ff;
   logic [pbfp_pkg::RAD_W-1:0]         radius_ff;
   logic [pbfp_pkg::EPS_W-1:0]         eps_ff;

   // Take a register write
   always_ff @(posedge clock) begin
      if (reset) begin
         bp_ff     <= '0;
         axis_ff   <= 1'b0;
         above_ff  <= 1'b1;
         stable_ff <= 1'b0;
         radius_ff <= 31'd6554;
         eps_ff    <= 16'd1;
      end else if (csr_we) begin
         case (csr_index)
            pbfp_pkg::CSR_BOUNDARY_POSITION: bp_ff     <= csr_wdata;
            pbfp_pkg::CSR_AXIS_IS_Y:         axis_ff   <= csr_wdata[0];
            pbfp_pkg::CSR_KEEP_ABOVE:        above_ff  <= csr_wdata[0];
            pbfp_pkg::CSR_STABLE_MODE:       stable_ff <= csr_wdata[0];
            pbfp_pkg::CSR_PARTICLE_RADIUS:   radius_ff <= csr_wdata[pbfp_pkg::RAD_W-1:0];
            pbfp_pkg::CSR_FRICTION_EPSILON:  eps_ff    <= csr_wdata[pbfp_pkg::EPS_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- pipeline control ----------------
   logic adv;
   logic a_vld_ff;
   logic p_vld_ff [0:NS];
   logic m_vld_ff;
   logic rsp_vld_ff;

   // Advance everything unless a result waits on a stalled receiver
   assign adv        = !rsp_vld_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = rsp_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff   <= 1'b0;
         m_vld_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
         for (int k = 0; k <= NS; k++) begin
            p_vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         a_vld_ff    <= req_tvalid;
         p_vld_ff[0] <= a_vld_ff;
         for (int k = 1; k <= NS; k++) begin
            p_vld_ff[k] <= p_vld_ff[k-1];
         end
         m_vld_ff   <= p_vld_ff[NS];
         rsp_vld_ff <= m_vld_ff;
      end
   end

   // ---------------- stage A: unpack, jitter, penetration test ----------------
   a_type                     a_in;
   a_type                     a_ff;
   logic signed [PW_-1:0]     in_ex, in_ey, in_px, in_py, est_n, est_t, prev_t;
   logic signed [PW_:0]       bp_ext, bound_hi, bound_lo, est_n_ext;
   logic [31:0]               jit_prod;

   always_comb begin
      in_ex  = req_tdata[O_EX +: PW_];
      in_ey  = req_tdata[O_EY +: PW_];
      in_px  = req_tdata[O_PX +: PW_];
      in_py  = req_tdata[O_PY +: PW_];
      est_n  = axis_ff ? in_ey : in_ex;
      est_t  = axis_ff ? in_ex : in_ey;
      prev_t = axis_ff ? in_px : in_py;
      bp_ext    = {bp_ff[PW_-1], bp_ff};
      est_n_ext = {est_n[PW_-1], est_n};
      bound_hi  = bp_ext + $signed({2'b00, radius_ff});
      bound_lo  = bp_ext - $signed({2'b00, radius_ff});
      jit_prod  = {16'd0, req_tdata[O_JIT +: pbfp_pkg::JIT_W]} * {16'd0, JIT_K};

      a_in.idx   = req_tdata[IDX_W-1:0];
      a_in.ex    = in_ex;
      a_in.ey    = in_ey;
      a_in.px    = in_px;
      a_in.py    = in_py;
      a_in.sf    = req_tdata[O_SF +: CW_];
      a_in.kf    = req_tdata[O_KF +: CW_];
      a_in.cnt   = req_tdata[O_CNT +: CNTW];
      a_in.hit   = above_ff ? (est_n_ext < bound_hi) : (est_n_ext > bound_lo);
      a_in.extra = req_tuser ? jit_prod[31:16] : 16'd0;
      a_in.diff  = {est_t[PW_-1], est_t} - {prev_t[PW_-1], prev_t};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff <= a_in;
      end
   end

   // ---------------- stage B: push distance, magnitude, unit setup ----------------
   it_type       b_in;
   logic [31:0]  d_sum;
   it_type       p_ff [0:NS];

   always_comb begin
      d_sum = {1'b0, radius_ff} + {16'd0, a_ff.extra};
      b_in.idx = a_ff.idx;
      b_in.ex  = a_ff.ex;
      b_in.ey  = a_ff.ey;
      b_in.px  = a_ff.px;
      b_in.py  = a_ff.py;
      b_in.hit = a_ff.hit;
      b_in.d   = d_sum[31] ? {pbfp_pkg::RAD_W{1'b1}} : d_sum[pbfp_pkg::RAD_W-1:0];
      b_in.neg = a_ff.diff[MAG_W-1];
      b_in.cnt = (a_ff.cnt == '0) ? CNTW'(1) : a_ff.cnt;
      b_in.dv.rem = '0;
      b_in.dv.num = DIV_W'(a_ff.diff[MAG_W-1] ? -a_ff.diff : a_ff.diff);
      b_in.ss.rad  = RAD2'(a_ff.sf) << FRAC_BITS;
      b_in.ss.rem  = '0;
      b_in.ss.root = '0;
      b_in.sk.rad  = RAD2'(a_ff.kf) << FRAC_BITS;
      b_in.sk.rem  = '0;
      b_in.sk.root = '0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff[0] <= b_in;
      end
   end

   // ---------------- divide and root slices ----------------
   for (genvar k = 0; k < NS; k++) begin : g_iter
      it_type slice_in;
      always_comb begin
         slice_in    = p_ff[k];
         slice_in.dv = div_step(p_ff[k].dv, p_ff[k].cnt);
         slice_in.ss = sqrt_step(p_ff[k].ss);
         slice_in.sk = sqrt_step(p_ff[k].sk);
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            p_ff[k+1] <= slice_in;
         end
      end
   end

   // ---------------- stage M: thresholds and plane coordinate ----------------
   m_type                m_in;
   m_type                m_ff;
   logic [PROD_W-1:0]    prod_s, prod_k;
   logic signed [PW_:0]  coord_ext;

   always_comb begin
      prod_s = PROD_W'(p_ff[NS].ss.root) * PROD_W'(p_ff[NS].d);
      prod_k = PROD_W'(p_ff[NS].sk.root) * PROD_W'(p_ff[NS].d);
      coord_ext = above_ff ? ({bp_ff[PW_-1], bp_ff} + $signed({2'b00, p_ff[NS].d}))
                           : ({bp_ff[PW_-1], bp_ff} - $signed({2'b00, p_ff[NS].d}));
      m_in.idx   = p_ff[NS].idx;
      m_in.ex    = p_ff[NS].ex;
      m_in.ey    = p_ff[NS].ey;
      m_in.px    = p_ff[NS].px;
      m_in.py    = p_ff[NS].py;
      m_in.hit   = p_ff[NS].hit;
      m_in.neg   = p_ff[NS].neg;
      m_in.q     = p_ff[NS].dv.num[MAG_W-1:0];
      m_in.ts    = prod_s[PROD_W-1:FRAC_BITS];
      m_in.tk    = prod_k[PROD_W-1:FRAC_BITS];
      m_in.coord = sat32({coord_ext[PW_], coord_ext});
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_ff <= m_in;
      end
   end

   // ---------------- stage F: friction and result ----------------
   logic [CMP_W-1:0]        qc, tsc, tkc, remc;
   logic                    fric;
   logic signed [PW_-1:0]   f_est_t, f_new_t, o_ex, o_ey, o_px, o_py;
   logic signed [PW_+1:0]   t_ext, r_ext;
   logic [IDX_W-1:0]        rsp_idx_ff;
   logic signed [PW_-1:0]   rsp_ex_ff, rsp_ey_ff, rsp_px_ff, rsp_py_ff;
   logic                    rsp_hit_ff;

   always_comb begin
      qc  = CMP_W'(m_ff.q);
      tsc = CMP_W'(m_ff.ts);
      tkc = CMP_W'(m_ff.tk);
      fric = m_ff.hit && !stable_ff && (qc >= CMP_W'(eps_ff));
      if (qc < tsc) begin
         remc = qc;
      end else begin
         remc = (tkc < qc) ? tkc : qc;
      end
      f_est_t = axis_ff ? m_ff.ex : m_ff.ey;
      t_ext   = {{2{f_est_t[PW_-1]}}, f_est_t};
      r_ext   = $signed({1'b0, remc[MAG_W-1:0]});
      f_new_t = fric ? sat32(m_ff.neg ? (t_ext + r_ext) : (t_ext - r_ext)) : f_est_t;

      o_ex = m_ff.ex;
      o_ey = m_ff.ey;
      o_px = m_ff.px;
      o_py = m_ff.py;
      if (axis_ff) begin
         o_ex = f_new_t;
         if (m_ff.hit) begin
            o_ey = m_ff.coord;
            if (stable_ff) begin
               o_py = m_ff.coord;
            end
         end
      end else begin
         o_ey = f_new_t;
         if (m_ff.hit) begin
            o_ex = m_ff.coord;
            if (stable_ff) begin
               o_px = m_ff.coord;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_idx_ff <= m_ff.idx;
         rsp_ex_ff  <= o_ex;
         rsp_ey_ff  <= o_ey;
         rsp_px_ff  <= o_px;
         rsp_py_ff  <= o_py;
         rsp_hit_ff <= m_ff.hit;
      end
   end

   assign rsp_tdata = RSP_W'({rsp_py_ff, rsp_px_ff, rsp_ey_ff, rsp_ex_ff, rsp_idx_ff});
   assign rsp_tuser = rsp_hit_ff;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for particle_boundary_friction_projector_core.
// Drives particles on the req_ stream, predicts each corrected particle and
// compares it with the rsp_ stream; depends on pbfp_pkg and the core.
module tb_top;

   localparam int IDX_W    = 12;
   localparam int POS_W    = pbfp_pkg::POS_W;
   localparam int JIT_W    = pbfp_pkg::JIT_W;
   localparam int COEF_W   = pbfp_pkg::COEF_W;
   localparam int REQ_BITS = IDX_W + 4 * POS_W + JIT_W + 2 * COEF_W + pbfp_pkg::CNT_W;
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS = IDX_W + 4 * POS_W;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;
   localparam int LATENCY  = 12;
   localparam longint S32_MAX = 64'sd2147483647;
   localparam longint S32_MIN = -64'sd2147483648;
   localparam longint JIT_SCALE = 197;
   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD = 200;

   typedef struct packed {
      logic [7:0]        count;
      logic [COEF_W-1:0] kin;
      logic [COEF_W-1:0] stat;
      logic [JIT_W-1:0]  jitter;
      logic [POS_W-1:0]  prev_y;
      logic [POS_W-1:0]  prev_x;
      logic [POS_W-1:0]  est_y;
      logic [POS_W-1:0]  est_x;
      logic [IDX_W-1:0]  index;
   } particle_type;

   typedef struct packed {
      logic              corrected;
      logic [POS_W-1:0]  prev_y;
      logic [POS_W-1:0]  prev_x;
      logic [POS_W-1:0]  est_y;
      logic [POS_W-1:0]  est_x;
      logic [IDX_W-1:0]  index;
   } corrected_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [pbfp_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [POS_W-1:0] csr_wdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic rsp_tuser;

   // Plane settings mirrored from the CSR writes
   longint plane_pos;
   bit     normal_y;
   bit     stay_above;
   bit     stable;
   longint radius;
   longint epsilon;

   corrected_type expected_q[$];
   int  mismatches = 0;
   int  cycles = 0;
   bit  rsp_idle_on = 1;
   bit  req_idle_on = 1;
   int  hold_rsp = 0;
   int  long_hold_reqs = 0;
   int  long_hold_done = 0;
   int  long_hold_left = 0;

   particle_boundary_friction_projector_core dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser), .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Timeout watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Long receiver hold-off, counted in cycles once requested
   always @(posedge clock) begin
      if (long_hold_left > 0) begin
         long_hold_left <= long_hold_left - 1;
      end else if (long_hold_reqs != long_hold_done) begin
         long_hold_done <= long_hold_done + 1;
         long_hold_left <= LONG_HOLD;
      end
   end

   function automatic longint sat32(longint v);
      if (v > S32_MAX) return S32_MAX;
      if (v < S32_MIN) return S32_MIN;
      return v;
   endfunction

   // Floor square root by bit-pair method
   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic longint friction_limit(longint unsigned coef, longint push);
      longint unsigned root;
      root = floor_sqrt(coef << 16);
      return longint'((root * longint'(push)) >> 16);
   endfunction

   // Compute the corrected particle for the current plane settings
   function automatic corrected_type project(particle_type p, bit fluid);
      longint est[2];
      longint prv[2];
      int nrm;
      int tng;
      longint extra;
      longint push;
      longint coord;
      longint step;
      longint mag;
      longint lim;
      longint rem;
      longint cnt;
      bit hit;
      corrected_type r;
      est[0] = longint'(signed'(p.est_x));
      est[1] = longint'(signed'(p.est_y));
      prv[0] = longint'(signed'(p.prev_x));
      prv[1] = longint'(signed'(p.prev_y));
      nrm = normal_y ? 1 : 0;
      tng = 1 - nrm;
      extra = fluid ? ((longint'(p.jitter) * JIT_SCALE) >>> 16) : 64'sd0;
      push = radius + extra;
      if (push > S32_MAX) push = S32_MAX;
      if (stay_above) begin
         hit = est[nrm] < plane_pos + radius;
         coord = sat32(plane_pos + push);
      end else begin
         hit = est[nrm] > plane_pos - radius;
         coord = sat32(plane_pos - push);
      end
      if (hit) begin
         est[nrm] = coord;
         if (stable) begin
            prv[nrm] = coord;
         end else begin
            cnt = (p.count == 8'd0) ? 64'sd1 : longint'(p.count);
            step = (est[tng] - prv[tng]) / cnt;
            mag = step < 0 ? -step : step;
            if (mag >= epsilon) begin
               lim = friction_limit(p.stat, push);
               if (mag < lim) begin
                  rem = mag;
               end else begin
                  lim = friction_limit(p.kin, push);
                  rem = lim < mag ? lim : mag;
               end
               if (step < 0) rem = -rem;
               est[tng] = sat32(est[tng] - rem);
            end
         end
      end
      r.index = p.index;
      r.est_x = est[0][31:0];
      r.est_y = est[1][31:0];
      r.prev_x = prv[0][31:0];
      r.prev_y = prv[1][31:0];
      r.corrected = hit;
      return r;
   endfunction

   // Receiver: random stalls, long hold-off on request, compare each transfer
   always @(posedge clock) begin
      corrected_type got;
      corrected_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata[RSP_BITS-1:0]};
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
               want = expected_q.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %h actual %h", want, got);
               end
            end
         end
         if (long_hold_left > 0) begin
            rsp_tready <= 1'b0;
         end else if (hold_rsp > 0) begin
            hold_rsp <= hold_rsp - 1;
            rsp_tready <= 1'b0;
         end else if (rsp_idle_on && $urandom_range(0, 7) == 0) begin
            hold_rsp <= $urandom_range(0, 9);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic write_csr(pbfp_pkg::csr_addr_type idx, logic [POS_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         pbfp_pkg::CSR_BOUNDARY_POSITION: plane_pos = longint'(signed'(val));
         pbfp_pkg::CSR_AXIS_IS_Y:         normal_y = val[0];
         pbfp_pkg::CSR_KEEP_ABOVE:        stay_above = val[0];
         pbfp_pkg::CSR_STABLE_MODE:       stable = val[0];
         pbfp_pkg::CSR_PARTICLE_RADIUS:   radius = longint'(val[30:0]);
         pbfp_pkg::CSR_FRICTION_EPSILON:  epsilon = longint'(val[15:0]);
         default: ;
      endcase
   endtask

   task automatic set_plane(longint pos, bit ay, bit above, bit stb, longint rad,
                            longint eps);
      write_csr(pbfp_pkg::CSR_BOUNDARY_POSITION, pos[31:0]);
      write_csr(pbfp_pkg::CSR_AXIS_IS_Y, {31'd0, ay});
      write_csr(pbfp_pkg::CSR_KEEP_ABOVE, {31'd0, above});
      write_csr(pbfp_pkg::CSR_STABLE_MODE, {31'd0, stb});
      write_csr(pbfp_pkg::CSR_PARTICLE_RADIUS, rad[31:0]);
      write_csr(pbfp_pkg::CSR_FRICTION_EPSILON, eps[31:0]);
   endtask

   // Send one particle; random idle burst before it
   task automatic send_particle(particle_type p, bit fluid);
      int gap;
      if (req_idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 10);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_W'(p);
      req_tuser <= fluid;
      expected_q.push_back(project(p, fluid));
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_pos(longint center);
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'h7fffffff;
         2: return 32'h80000000;
         default: return 32'(center + $signed($urandom_range(0, 40000)) - 20000);
      endcase
   endfunction

   function automatic particle_type rand_particle();
      particle_type p;
      longint c;
      p.index = IDX_W'($urandom);
      c = plane_pos + (stay_above ? radius : -radius);
      p.est_x = rand_pos(normal_y ? 64'sd0 : c);
      p.est_y = rand_pos(normal_y ? c : 64'sd0);
      p.prev_x = ($urandom_range(0, 3) == 0) ? 32'($urandom) :
                 32'(signed'(p.est_x) + $signed($urandom_range(0, 400000)) - 200000);
      p.prev_y = ($urandom_range(0, 3) == 0) ? 32'($urandom) :
                 32'(signed'(p.est_y) + $signed($urandom_range(0, 400000)) - 200000);
      p.jitter = JIT_W'($urandom);
      p.stat = COEF_W'($urandom);
      p.kin = COEF_W'($urandom);
      p.count = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 4));
      return p;
   endfunction

   task automatic test_directed();
      particle_type p;
      int i;
      set_plane(64'sd0, 1'b0, 1'b1, 1'b0, 64'sd6554, 64'sd1);
      for (i = 0; i < 24; i++) begin
         p = rand_particle();
         case (i)
            0: begin p.est_x = 32'h80000000; p.prev_x = 32'h7fffffff; end
            1: begin p.est_x = 32'h7fffffff; end
            2: begin p.est_x = 32'd6553; p.est_y = 32'h7fffffff;
                     p.prev_y = 32'h80000000; p.stat = '0; p.kin = '1; end
            3: begin p.est_x = 32'd6554; end
            4: begin p.est_x = 32'd0; p.est_y = 32'h80000000; p.prev_y = 32'h7fffffff;
                     p.stat = '1; p.count = 8'd1; end
            5: begin p.est_x = 32'd0; p.count = 8'd0; p.index = '1; p.jitter = '1; end
            6: begin p.est_x = 32'd0; p.est_y = 32'd100; p.prev_y = 32'd100; end
            7: begin p.est_x = 32'd0; p.count = 8'hff; p.index = '0; p.jitter = '0; end
            default: ;
         endcase
         send_particle(p, i[0]);
         if (i == 11) begin
            drain();
            set_plane(-64'sd2147483648, 1'b1, 1'b0, 1'b1, 64'sd2147483647, 64'sd65535);
         end
      end
      drain();
   endtask

   task automatic test_random(int n);
      int i;
      longint pos;
      for (i = 0; i < n; i++) begin
         if (i % 100 == 0) begin
            drain();
            pos = ($urandom_range(0, 4) == 0) ? longint'(signed'(32'($urandom))) :
                  longint'($urandom_range(0, 200000)) - 100000;
            set_plane(pos, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      $urandom_range(0, 3) == 0,
                      ($urandom_range(0, 5) == 0) ? longint'($urandom_range(0, 32'h7fffffff))
                                                   : longint'($urandom_range(0, 20000)),
                      ($urandom_range(0, 5) == 0) ? 64'sd65535
                                                   : longint'($urandom_range(0, 64)));
         end
         send_particle(rand_particle(), 1'($urandom_range(0, 1)));
      end
      drain();
   endtask

   task automatic test_backpressure();
      int i;
      long_hold_reqs++;
      for (i = 0; i < 60; i++) send_particle(rand_particle(), 1'($urandom_range(0, 1)));
      drain();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      plane_pos = 0; normal_y = 0; stay_above = 1; stable = 0;
      radius = 6554; epsilon = 1;
      test_directed();
      test_random(550);
      test_backpressure();
      // final stretch without idling
      req_idle_on = 0;
      rsp_idle_on = 0;
      test_random(100);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

/* filelist.f */
sv/pbfp_pkg.sv
sv/particle_boundary_friction_projector_core.sv
tb/tb_top.sv
